FILE: rtl/assert_macros.svh
// Assertion helper macros shared by the RTL files.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property checked every clock, masked during reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error(msg);

`endif

FILE: rtl/wdc_pkg.sv
// Types and constants for the WAVE data chunk parser.
// No dependencies.
package wdc_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam int unsigned FIFO_DEPTH = 4;

  typedef enum logic [2:0] {
    PH_RIFF  = 3'd0,
    PH_RSIZE = 3'd1,
    PH_WAVE  = 3'd2,
    PH_CTAG  = 3'd3,
    PH_CSIZE = 3'd4,
    PH_SKIP  = 3'd5,
    PH_DATA  = 3'd6,
    PH_DRAIN = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0,
    KIND_OK    = 2'd1,
    KIND_BAD   = 2'd2
  } kind_e;

  typedef struct packed {
    logic signed [15:0] sample;
    kind_e              kind;
    logic               last;
  } res_t;

  typedef struct packed {
    logic push0;
    logic push1;
    res_t r0;
    res_t r1;
  } push_t;

endpackage

FILE: rtl/wdc_if.sv
// Stream interfaces for the byte input and the result output.
// Depends on wdc_pkg.
interface wdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface wdc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  wdc_pkg::kind_e     kind;
  logic               last_of_run;

  modport source (output valid, output left_sample, output right_sample, output kind,
                  output last_of_run, input ready);
  modport sink (input valid, input left_sample, input right_sample, input kind,
                input last_of_run, output ready);
endinterface

FILE: rtl/wav_data_chunk_to_stereo_pcm.sv
// WAVE file byte stream to 16-bit PCM, each sample driven on both the left and the right
// output: one byte accepted per cycle while the result queue has room for two results.
// Throughput: one byte per cycle while the queue has room for two; the byte carrying end of
// file may yield two results, which drain through a four-entry registered result queue.
// Reset (rst_ni low, asynchronous) restarts the parser at the RIFF tag and empties the queue.
module wav_data_chunk_to_stereo_pcm #(
  parameter int unsigned FIFO_DEPTH = wdc_pkg::FIFO_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wdc_in_if.sink    in_i,
  wdc_out_if.source out_o
);
  import wdc_pkg::*;

  push_t push;
  res_t  res;
  logic  space2;
  logic  acc;

  assign in_i.ready = space2;
  assign acc        = in_i.valid && in_i.ready;

  wdc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .data_byte_i (in_i.data_byte),
    .eof_i       (in_i.end_of_file),
    .push_o      (push)
  );

  wdc_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .space2_o (space2),
    .valid_o  (out_o.valid),
    .ready_i  (out_o.ready),
    .res_o    (res)
  );

  assign out_o.left_sample  = res.sample;
  assign out_o.right_sample = res.sample;
  assign out_o.kind         = res.kind;
  assign out_o.last_of_run  = res.last;

endmodule

FILE: rtl/wdc_parser.sv
// RIFF/WAVE header parser state machine; emits up to two results per byte.
// Depends on wdc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wdc_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          acc_i,
  input  logic [7:0]    data_byte_i,
  input  logic          eof_i,
  output wdc_pkg::push_t push_o
);
  import wdc_pkg::*;

  phase_e      phase_q, phase_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] skip_q, skip_d;
  logic [7:0]  low_q, low_d;
  logic        held_q, held_d;

  logic [31:0] tag_nx;
  logic [31:0] size_nx;
  logic        done4;
  logic        bad_tag;

  assign tag_nx = {tag_q[23:0], data_byte_i};
  assign done4  = (cnt_q == 2'd3);

  always_comb begin
    size_nx = skip_q;
    case (cnt_q)
      2'd0:    size_nx[7:0]   = skip_q[7:0]   | data_byte_i;
      2'd1:    size_nx[15:8]  = skip_q[15:8]  | data_byte_i;
      2'd2:    size_nx[23:16] = skip_q[23:16] | data_byte_i;
      default: size_nx[31:24] = skip_q[31:24] | data_byte_i;
    endcase
  end

  assign bad_tag = done4 && (((phase_q == PH_RIFF) && (tag_nx != TAG_RIFF)) ||
                             ((phase_q == PH_WAVE) && (tag_nx != TAG_WAVE)));

  // next state
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    tag_d   = tag_q;
    skip_d  = skip_q;
    low_d   = low_q;
    held_d  = held_q;
    if (acc_i) begin
      if (eof_i) begin
        phase_d = PH_RIFF;
        cnt_d   = '0;
        tag_d   = '0;
        skip_d  = '0;
        low_d   = '0;
        held_d  = 1'b0;
      end else begin
        case (phase_q)
          PH_RIFF, PH_WAVE, PH_CTAG: begin
            tag_d = tag_nx;
            cnt_d = cnt_q + 2'd1;
            if (done4) begin
              if (bad_tag) begin
                phase_d = PH_DRAIN;
              end else if (phase_q == PH_RIFF) begin
                phase_d = PH_RSIZE;
              end else if (phase_q == PH_WAVE) begin
                phase_d = PH_CTAG;
              end else begin
                skip_d  = '0;
                phase_d = PH_CSIZE;
              end
            end
          end
          PH_RSIZE: begin
            cnt_d = cnt_q + 2'd1;
            if (done4) phase_d = PH_WAVE;
          end
          PH_CSIZE: begin
            skip_d = size_nx;
            cnt_d  = cnt_q + 2'd1;
            if (done4) begin
              if (tag_q == TAG_DATA) begin
                phase_d = PH_DATA;
                held_d  = 1'b0;
              end else if (size_nx == '0) begin
                phase_d = PH_CTAG;
              end else begin
                phase_d = PH_SKIP;
              end
            end
          end
          PH_SKIP: begin
            skip_d = skip_q - 32'd1;
            if (skip_q == 32'd1) phase_d = PH_CTAG;
          end
          PH_DATA: begin
            if (held_q) begin
              held_d = 1'b0;
            end else begin
              low_d  = data_byte_i;
              held_d = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // result generation
  always_comb begin
    push_o = '0;
    push_o.r0.kind = KIND_FRAME;
    push_o.r1.kind = KIND_FRAME;
    if (acc_i) begin
      case (phase_q)
        PH_RIFF, PH_WAVE, PH_RSIZE, PH_CTAG, PH_SKIP: begin
          if (bad_tag || eof_i) begin
            push_o.push0   = 1'b1;
            push_o.r0.kind = KIND_BAD;
            push_o.r0.last = 1'b1;
          end
        end
        PH_CSIZE: begin
          if (eof_i) begin
            push_o.push0   = 1'b1;
            push_o.r0.kind = (done4 && (tag_q == TAG_DATA)) ? KIND_OK : KIND_BAD;
            push_o.r0.last = 1'b1;
          end
        end
        PH_DATA: begin
          if (held_q) begin
            push_o.push0     = 1'b1;
            push_o.r0.sample = {data_byte_i, low_q};
            push_o.r0.kind   = KIND_FRAME;
            push_o.r0.last   = !eof_i;
            if (eof_i) begin
              push_o.push1   = 1'b1;
              push_o.r1.kind = KIND_OK;
              push_o.r1.last = 1'b1;
            end
          end else if (eof_i) begin
            push_o.push0   = 1'b1;
            push_o.r0.kind = KIND_OK;
            push_o.r0.last = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF;
      cnt_q   <= '0;
      tag_q   <= '0;
      skip_q  <= '0;
      low_q   <= '0;
      held_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      tag_q   <= tag_d;
      skip_q  <= skip_d;
      low_q   <= low_d;
      held_q  <= held_d;
    end
  end

  `ASSERT_CLK(a_two_only_at_eof, clk_i, rst_ni, push_o.push1 |-> (push_o.push0 && eof_i), "second result without end of file")
  `ASSERT_CLK(a_eof_resets, clk_i, rst_ni, (acc_i && eof_i) |=> (phase_q == PH_RIFF && !held_q), "end of file did not restart parser")
  `ASSERT_NEVER(a_skip_zero, clk_i, rst_ni, phase_q == PH_SKIP && skip_q == '0, "skip phase with no bytes left")

endmodule

FILE: rtl/wdc_out_fifo.sv
// Small result queue taking up to two results per cycle, one out per transaction.
// Depends on wdc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wdc_out_fifo #(
  parameter int unsigned DEPTH = wdc_pkg::FIFO_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  wdc_pkg::push_t push_i,
  output logic           space2_o,
  output logic           valid_o,
  input  logic           ready_i,
  output wdc_pkg::res_t  res_o
);
  import wdc_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

  res_t          mem_q [DEPTH];
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d, wp1;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pop;

  function automatic logic [PW-1:0] inc_ptr(input logic [PW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + PW'(1);
  endfunction

  assign pop      = valid_o && ready_i;
  assign valid_o  = (cnt_q != '0);
  assign res_o    = mem_q[rp_q];
  assign space2_o = (cnt_q <= CW'(DEPTH - 2));
  assign wp1      = inc_ptr(wp_q);

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i.push0) wp_d = push_i.push1 ? inc_ptr(wp1) : wp1;
    if (pop) rp_d = inc_ptr(rp_q);
    cnt_d = cnt_q + CW'(push_i.push0) + CW'(push_i.push1) - CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) mem_q[wp_q] <= push_i.r0;
    if (push_i.push1) mem_q[wp1] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  `ASSERT_NEVER(a_overflow, clk_i, rst_ni, cnt_q > CW'(DEPTH), "result queue overflow")
  `ASSERT_CLK(a_push_room, clk_i, rst_ni, push_i.push0 |-> space2_o, "push without room for two")
  `ASSERT_CLK(a_ptr_track, clk_i, rst_ni, (cnt_q == '0) |-> (wp_q == rp_q), "empty queue with unequal pointers")

endmodule

FILE: bench/tb_wav_data_chunk_to_stereo_pcm.sv
// Testbench for wav_data_chunk_to_stereo_pcm: feeds WAVE file bytes and checks every result
// against an in-bench parser model, with random idling and a long output stall.
// Depends on wav_data_chunk_to_stereo_pcm, wdc_pkg, wdc_in_if and wdc_out_if.
module tb_wav_data_chunk_to_stereo_pcm;
  timeunit 1ns;
  timeprecision 1ps;

  import wdc_pkg::*;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    kind_e              kind;
    logic               last;
  } pcm_result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic       typed;
    kind_e      kind;
  } byte_row_t;

  localparam int NUM_ROWS = 29;
  localparam byte_row_t DIRECTED_ROWS[NUM_ROWS] = '{
    '{8'h52, 1'b0, 1'b0, KIND_FRAME}, '{8'h49, 1'b0, 1'b0, KIND_FRAME},
    '{8'h46, 1'b0, 1'b0, KIND_FRAME}, '{8'h58, 1'b0, 1'b1, KIND_BAD},
    '{8'h00, 1'b1, 1'b0, KIND_FRAME},
    '{8'h52, 1'b0, 1'b0, KIND_FRAME}, '{8'h49, 1'b0, 1'b0, KIND_FRAME},
    '{8'h46, 1'b0, 1'b0, KIND_FRAME}, '{8'h46, 1'b0, 1'b0, KIND_FRAME},
    '{8'hff, 1'b0, 1'b0, KIND_FRAME}, '{8'h00, 1'b0, 1'b0, KIND_FRAME},
    '{8'hff, 1'b0, 1'b0, KIND_FRAME}, '{8'h00, 1'b0, 1'b0, KIND_FRAME},
    '{8'h57, 1'b0, 1'b0, KIND_FRAME}, '{8'h41, 1'b0, 1'b0, KIND_FRAME},
    '{8'h56, 1'b0, 1'b0, KIND_FRAME}, '{8'h45, 1'b0, 1'b0, KIND_FRAME},
    '{8'h64, 1'b0, 1'b0, KIND_FRAME}, '{8'h61, 1'b0, 1'b0, KIND_FRAME},
    '{8'h74, 1'b0, 1'b0, KIND_FRAME}, '{8'h61, 1'b0, 1'b0, KIND_FRAME},
    '{8'h00, 1'b0, 1'b0, KIND_FRAME}, '{8'h00, 1'b0, 1'b0, KIND_FRAME},
    '{8'h00, 1'b0, 1'b0, KIND_FRAME}, '{8'h80, 1'b0, 1'b0, KIND_FRAME},
    '{8'h00, 1'b0, 1'b0, KIND_FRAME}, '{8'h80, 1'b0, 1'b1, KIND_FRAME},
    '{8'hff, 1'b0, 1'b0, KIND_FRAME}, '{8'h7f, 1'b1, 1'b1, KIND_OK}
  };

  localparam int RANDOM_BYTES = 1300;

  logic clk_i;
  logic rst_ni;

  wdc_in_if  byte_bus ();
  wdc_out_if pcm_bus ();

  wav_data_chunk_to_stereo_pcm dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_bus.sink),
    .out_o  (pcm_bus.source)
  );

  pcm_result_t pcm_results_due[$];
  logic [7:0]  wave_file[$];

  phase_e      p_phase;
  logic [1:0]  p_count;
  logic [31:0] p_tag;
  logic [31:0] p_skip;
  logic [7:0]  p_low;
  logic        p_held;

  int  errors = 0;
  int  bytes_sent = 0;
  bit  calm = 1'b0;
  int  hold_cycles = 0;
  bit  hold_done = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void parser_restart();
    p_phase = PH_RIFF;
    p_count = 2'd0;
    p_tag   = 32'd0;
    p_skip  = 32'd0;
    p_low   = 8'd0;
    p_held  = 1'b0;
  endfunction

  function automatic void expect_result(logic [15:0] sample, kind_e kind, logic last);
    pcm_result_t r;
    r.left  = sample;
    r.right = sample;
    r.kind  = kind;
    r.last  = last;
    pcm_results_due.push_back(r);
  endfunction

  function automatic void parse_wave_byte(logic [7:0] b, logic eof);
    logic field_done;
    logic eof_bad;
    field_done = (p_count == 2'd3);
    eof_bad = 1'b1;
    case (p_phase)
      PH_RIFF, PH_WAVE, PH_CTAG: begin
        p_tag = {p_tag[23:0], b};
        p_count++;
        if (field_done) begin
          if ((p_phase == PH_RIFF && p_tag != TAG_RIFF) ||
              (p_phase == PH_WAVE && p_tag != TAG_WAVE)) begin
            expect_result(16'd0, KIND_BAD, 1'b1);
            eof_bad = 1'b0;
            p_phase = PH_DRAIN;
          end else if (p_phase == PH_RIFF) begin
            p_phase = PH_RSIZE;
          end else if (p_phase == PH_WAVE) begin
            p_phase = PH_CTAG;
          end else begin
            p_skip = 32'd0;
            p_phase = PH_CSIZE;
          end
        end
      end
      PH_RSIZE: begin
        p_count++;
        if (field_done) p_phase = PH_WAVE;
      end
      PH_CSIZE: begin
        p_skip[8*p_count +: 8] = b;
        p_count++;
        if (field_done) begin
          if (p_tag == TAG_DATA) begin
            p_phase = PH_DATA;
            p_held = 1'b0;
            if (eof) begin
              expect_result(16'd0, KIND_OK, 1'b1);
              eof_bad = 1'b0;
            end
          end else if (p_skip == 32'd0) begin
            p_phase = PH_CTAG;
          end else begin
            p_phase = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        p_skip--;
        if (p_skip == 32'd0) p_phase = PH_CTAG;
      end
      PH_DATA: begin
        if (p_held) begin
          expect_result({b, p_low}, KIND_FRAME, !eof);
          p_held = 1'b0;
        end else begin
          p_low = b;
          p_held = 1'b1;
        end
        if (eof) expect_result(16'd0, KIND_OK, 1'b1);
        eof_bad = 1'b0;
      end
      default: eof_bad = 1'b0;
    endcase
    if (eof) begin
      if (eof_bad) expect_result(16'd0, KIND_BAD, 1'b1);
      parser_restart();
    end
  endfunction

  function automatic void put_tag(logic [31:0] tag);
    for (int i = 3; i >= 0; i--) wave_file.push_back(tag[8*i +: 8]);
  endfunction

  function automatic void put_le32(logic [31:0] value);
    for (int i = 0; i < 4; i++) wave_file.push_back(value[8*i +: 8]);
  endfunction

  // Mostly well-formed files with random content; some corrupted, truncated or pure noise.
  function automatic void build_wave_file();
    int mode;
    int size;
    int cut;
    wave_file.delete();
    mode = $urandom_range(0, 99);
    if (mode < 85) begin
      put_tag(TAG_RIFF);
      put_le32($urandom());
      put_tag(TAG_WAVE);
      repeat ($urandom_range(0, 2)) begin
        put_tag($urandom());
        size = $urandom_range(0, 6);
        put_le32(size);
        repeat (size) wave_file.push_back(8'($urandom()));
      end
      put_tag(TAG_DATA);
      put_le32($urandom());
      repeat ($urandom_range(0, 60)) wave_file.push_back(8'($urandom()));
      if (mode >= 60 && mode < 72) begin
        wave_file[$urandom_range(0, 11)] = 8'($urandom());
      end else if (mode >= 72) begin
        cut = $urandom_range(1, wave_file.size());
        while (wave_file.size() > cut) void'(wave_file.pop_back());
      end
    end else begin
      repeat ($urandom_range(1, 12)) wave_file.push_back(8'($urandom()));
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eof);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 22) begin
      byte_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    byte_bus.valid       <= 1'b1;
    byte_bus.data_byte   <= b;
    byte_bus.end_of_file <= eof;
    @(posedge clk_i);
    while (!byte_bus.ready) @(posedge clk_i);
    parse_wave_byte(b, eof);
    bytes_sent++;
    calm = (bytes_sent >= 700 && bytes_sent < 900);
  endtask

  // Result side: random backpressure plus one long hold while samples are flowing.
  always @(negedge clk_i) begin
    if (hold_cycles == 0 && !hold_done && bytes_sent >= 400 && p_phase == PH_DATA) begin
      hold_cycles = 80;
      hold_done = 1'b1;
    end
    if (hold_cycles > 0) begin
      pcm_bus.ready <= 1'b0;
      hold_cycles--;
    end else begin
      pcm_bus.ready <= calm || ($urandom_range(0, 99) >= 22);
    end
  end

  always @(posedge clk_i) begin
    pcm_result_t want;
    if (rst_ni && pcm_bus.valid && pcm_bus.ready) begin
      if (pcm_results_due.size() == 0) begin
        $display("%0t: unexpected transaction: left %0d right %0d kind %0d last %0d",
                 $time, pcm_bus.left_sample, pcm_bus.right_sample, pcm_bus.kind,
                 pcm_bus.last_of_run);
        errors++;
      end else begin
        want = pcm_results_due.pop_front();
        if (pcm_bus.left_sample !== want.left || pcm_bus.right_sample !== want.right ||
            pcm_bus.kind !== want.kind || pcm_bus.last_of_run !== want.last) begin
          $display("%0t: expected left %0d right %0d kind %0d last %0d, got %0d %0d %0d %0d",
                   $time, want.left, want.right, want.kind, want.last,
                   pcm_bus.left_sample, pcm_bus.right_sample, pcm_bus.kind,
                   pcm_bus.last_of_run);
          errors++;
        end
      end
    end
  end

  initial begin
    #400_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    byte_bus.valid = 1'b0;
    byte_bus.data_byte = 8'd0;
    byte_bus.end_of_file = 1'b0;
    parser_restart();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED_ROWS[i]) begin
      send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].eof);
      if (DIRECTED_ROWS[i].typed &&
          (pcm_results_due.size() == 0 ||
           pcm_results_due[$].kind !== DIRECTED_ROWS[i].kind)) begin
        $display("%0t: row %0d expected kind %0d, model gave none or other", $time, i,
                 DIRECTED_ROWS[i].kind);
        errors++;
      end
    end

    while (bytes_sent < NUM_ROWS + RANDOM_BYTES) begin
      build_wave_file();
      foreach (wave_file[i]) send_byte(wave_file[i], i == wave_file.size() - 1);
    end
    @(negedge clk_i);
    byte_bus.valid <= 1'b0;

    while (pcm_results_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
